// File: src/atrsp_pkg.sv
// shared constants, codes and word types of the modem response parser
`timescale 1ns / 1ps
package atrsp_pkg;

   // line buffer
   localparam int LINE_CHARS = 160;
   localparam int LINE_DEPTH = LINE_CHARS - 1;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

   // payload buffer
   localparam int PAYLOAD_DEPTH = 512;
   localparam int PL_AW         = $clog2(PAYLOAD_DEPTH);
   localparam int PL_CW         = $clog2(PAYLOAD_DEPTH + 1);

   // item modes
   localparam logic [2:0] MODE_BYTE       = 3'd0;
   localparam logic [2:0] MODE_READ       = 3'd1;
   localparam logic [2:0] MODE_ARM_SEND   = 3'd2;
   localparam logic [2:0] MODE_ARM_CONN   = 3'd3;
   localparam logic [2:0] MODE_DISCONNECT = 3'd4;

   // read status codes
   localparam logic [1:0] RD_OK       = 2'd0;
   localparam logic [1:0] RD_NOT_CONN = 2'd1;
   localparam logic [1:0] RD_EMPTY    = 2'd2;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       link_up;
      logic       connect_seen;
      logic       send_seen;
      logic       prompt_seen;
      logic       data_valid;
      logic [7:0] data_out;
      logic [1:0] read_status;
      logic [9:0] stored_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic lend;
      logic copy;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic line_end_req;
      logic scan_stop;
      logic hdr_go;
      logic copy_done;
   } sts_type;

endpackage

// File: src/atrsp_ctrl.sv
// controller state machine of the modem response parser
`timescale 1ns / 1ps
module atrsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  atrsp_pkg::sts_type  sts,
   output atrsp_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_LEND = 3'd3;
   localparam logic [2:0] ST_COPY = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.line_end_req ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_stop) state_in = ST_LEND;
         end
         ST_LEND: begin
            cmd.lend = 1'b1;
            state_in = sts.hdr_go ? ST_COPY : ST_DONE;
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (sts.copy_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/atrsp_dp.sv
// datapath of the modem response parser: buffers, line matcher, header parser
`timescale 1ns / 1ps
module atrsp_dp (
   input  logic                clock,
   input  logic                reset,
   input  atrsp_pkg::cmd_type  cmd,
   input  atrsp_pkg::req_type  req_data,
   output atrsp_pkg::sts_type  sts,
   output atrsp_pkg::rsp_type  rsp_data
);

   localparam int WIN_BYTES = 15;
   localparam int WIN_W     = WIN_BYTES * 8;

   localparam logic [79:0]  PAT_CONNECT_OK = "CONNECT OK";
   localparam logic [119:0] PAT_ALREADY    = "ALREADY CONNECT";
   localparam logic [55:0]  PAT_SEND_OK    = "SEND OK";
   localparam logic [47:0]  PAT_CLOSED     = "CLOSED";
   localparam logic [63:0]  PAT_CLOSE_OK   = "CLOSE OK";
   localparam logic [39:0]  PAT_IPD        = "+IPD,";

   localparam logic [7:0] CH_PROMPT = 8'h3E;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [atrsp_pkg::LEN_W-1:0] HDR_LAST = atrsp_pkg::LEN_W'(4);
   localparam logic [atrsp_pkg::LEN_W-1:0] HDR_LEN  = atrsp_pkg::LEN_W'(5);

   localparam logic [1:0] PH_WS  = 2'd0;
   localparam logic [1:0] PH_DIG = 2'd1;
   localparam logic [1:0] PH_END = 2'd2;

   localparam logic [atrsp_pkg::PL_CW-1:0] PL_FULL =
      atrsp_pkg::PL_CW'(atrsp_pkg::PAYLOAD_DEPTH);
   localparam logic [atrsp_pkg::LEN_W-1:0] LINE_MAX =
      atrsp_pkg::LEN_W'(atrsp_pkg::LINE_DEPTH);

   // memories
   logic [7:0] line_mem [atrsp_pkg::LINE_DEPTH];
   logic [7:0] pl_mem   [atrsp_pkg::PAYLOAD_DEPTH];

   atrsp_pkg::req_type item_ff;

   // control state
   logic [atrsp_pkg::LEN_W-1:0] len_ff, len_in;
   logic [atrsp_pkg::PL_CW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [15:0]                 pend_ff, pend_in;
   logic link_ff, link_in, conn_ff, conn_in, send_ff, send_in, prompt_ff, prompt_in;

   // scan state
   logic [atrsp_pkg::LEN_W-1:0] idx_ff, idx_in, colon_ff, colon_in;
   logic [WIN_W-1:0]            win_ff, win_in;
   logic m_conn_ff, m_conn_in, m_send_ff, m_send_in, m_close_ff, m_close_in;
   logic hdr_ff, hdr_in, cfound_ff, cfound_in, neg_ff, neg_in;
   logic [1:0]                  ph_ff, ph_in;
   logic [15:0]                 acc_ff, acc_in;

   // copy state
   logic [15:0]                 accf_ff, accf_in;
   logic [atrsp_pkg::LEN_W-1:0] cnt_ff, cnt_in, cp_ff, cp_in;

   // per item result
   logic       rv_ff, rv_in;
   logic [7:0] rdat_ff, rdat_in;
   logic [1:0] rst_ff, rst_in;

   // memory ports
   logic [atrsp_pkg::LEN_W-1:0] lrd_addr;
   logic [7:0]                  lrd_ff, pl_rd_ff;
   logic                        lwr_en, pwr_en;
   logic [atrsp_pkg::PL_AW-1:0] pwr_addr;
   logic [7:0]                  pwr_data;

   atrsp_pkg::rsp_type out_ff;

   logic [7:0]                  c;
   logic                        c_digit, c_space;
   logic [15:0]                 dval, acc_fin, avail16, space16, m1;
   logic [atrsp_pkg::PL_CW-1:0] rd_next;

   assign c       = lrd_ff;
   assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign c_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign dval    = {12'd0, c[3:0]};
   assign acc_fin = neg_ff ? (16'd0 - acc_ff) : acc_ff;
   assign avail16 = 16'(idx_ff - colon_ff - atrsp_pkg::LEN_W'(1));
   assign space16 = 16'(PL_FULL - wr_ff);
   assign m1      = (avail16 < acc_fin) ? avail16 : acc_fin;
   assign rd_next = rd_ff + atrsp_pkg::PL_CW'(1);

   assign sts.line_end_req = (item_ff.mode == atrsp_pkg::MODE_BYTE) &&
                             (item_ff.rx_byte == CH_LF) && (pend_ff == 16'd0) &&
                             (len_ff != '0);
   assign sts.scan_stop    = (idx_ff >= len_ff) || (lrd_ff == 8'd0);
   assign sts.hdr_go       = !m_conn_ff && !m_send_ff && !m_close_ff && hdr_ff && cfound_ff;
   assign sts.copy_done    = (cp_ff == cnt_ff);

   always_comb begin
      len_in = len_ff;  wr_in = wr_ff;  rd_in = rd_ff;  pend_in = pend_ff;
      link_in = link_ff;  conn_in = conn_ff;  send_in = send_ff;  prompt_in = prompt_ff;
      idx_in = idx_ff;  colon_in = colon_ff;  win_in = win_ff;
      m_conn_in = m_conn_ff;  m_send_in = m_send_ff;  m_close_in = m_close_ff;
      hdr_in = hdr_ff;  cfound_in = cfound_ff;  neg_in = neg_ff;
      ph_in = ph_ff;  acc_in = acc_ff;
      accf_in = accf_ff;  cnt_in = cnt_ff;  cp_in = cp_ff;
      rv_in = rv_ff;  rdat_in = rdat_ff;  rst_in = rst_ff;
      lwr_en = 1'b0;  pwr_en = 1'b0;
      pwr_addr = wr_ff[atrsp_pkg::PL_AW-1:0];
      pwr_data = item_ff.rx_byte;

      if (cmd.load) begin
         rv_in = 1'b0;  rdat_in = 8'd0;  rst_in = atrsp_pkg::RD_OK;
      end

      if (cmd.exec) begin
         case (item_ff.mode)
            atrsp_pkg::MODE_BYTE: begin
               if (item_ff.rx_byte == CH_PROMPT) begin
                  prompt_in = 1'b1;
               end else if (pend_ff != 16'd0) begin
                  if (wr_ff < PL_FULL) begin
                     pwr_en = 1'b1;
                     wr_in  = wr_ff + atrsp_pkg::PL_CW'(1);
                  end
                  pend_in = pend_ff - 16'd1;
               end else if (item_ff.rx_byte == CH_LF) begin
                  // start a scan of the line
                  idx_in = '0;  win_in = '0;  colon_in = '0;
                  m_conn_in = 1'b0;  m_send_in = 1'b0;  m_close_in = 1'b0;
                  hdr_in = 1'b0;  cfound_in = 1'b0;  neg_in = 1'b0;
                  ph_in = PH_WS;  acc_in = 16'd0;
               end else if (item_ff.rx_byte != CH_CR) begin
                  if (len_ff < LINE_MAX) begin
                     lwr_en = 1'b1;
                     len_in = len_ff + atrsp_pkg::LEN_W'(1);
                  end
               end
            end
            atrsp_pkg::MODE_READ: begin
               if (!link_ff) begin
                  rst_in = atrsp_pkg::RD_NOT_CONN;
               end else if ((rd_ff >= wr_ff) || (rd_ff >= PL_FULL)) begin
                  rd_in = '0;  wr_in = '0;  rst_in = atrsp_pkg::RD_EMPTY;
               end else begin
                  rv_in   = 1'b1;
                  rdat_in = pl_rd_ff;
                  rd_in   = rd_next;
                  if (rd_next >= wr_ff) begin
                     rd_in = '0;  wr_in = '0;
                  end
               end
            end
            atrsp_pkg::MODE_ARM_SEND: begin
               prompt_in = 1'b0;  send_in = 1'b0;
            end
            atrsp_pkg::MODE_ARM_CONN: begin
               link_in = 1'b0;  conn_in = 1'b0;
            end
            atrsp_pkg::MODE_DISCONNECT: link_in = 1'b0;
            default: ;
         endcase
      end

      if (cmd.scan && !sts.scan_stop) begin
         win_in = {win_ff[WIN_W-9:0], c};
         if ((win_in[79:0] == PAT_CONNECT_OK) || (win_in[119:0] == PAT_ALREADY))
            m_conn_in = 1'b1;
         if (win_in[55:0] == PAT_SEND_OK) m_send_in = 1'b1;
         if ((win_in[47:0] == PAT_CLOSED) || (win_in[63:0] == PAT_CLOSE_OK))
            m_close_in = 1'b1;
         if ((idx_ff == HDR_LAST) && (win_in[39:0] == PAT_IPD)) hdr_in = 1'b1;
         if (idx_ff >= HDR_LEN) begin
            if (!cfound_ff && (c == CH_COLON)) begin
               cfound_in = 1'b1;
               colon_in  = idx_ff;
            end
            // decimal length, parsed like atoi
            case (ph_ff)
               PH_WS: begin
                  if (c_space) begin
                     ph_in = PH_WS;
                  end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                     neg_in = (c == CH_MINUS);
                     ph_in  = PH_DIG;
                  end else if (c_digit) begin
                     acc_in = dval;
                     ph_in  = PH_DIG;
                  end else begin
                     ph_in = PH_END;
                  end
               end
               PH_DIG: begin
                  if (c_digit) acc_in = {acc_ff[12:0], 3'b0} + {acc_ff[14:0], 1'b0} + dval;
                  else ph_in = PH_END;
               end
               default: ;
            endcase
         end
         idx_in = idx_ff + atrsp_pkg::LEN_W'(1);
      end

      if (cmd.lend) begin
         len_in = '0;
         cp_in  = '0;
         accf_in = acc_fin;
         cnt_in = atrsp_pkg::LEN_W'((m1 < space16) ? m1 : space16);
         if (m_conn_ff) begin
            link_in = 1'b1;  conn_in = 1'b1;
         end else if (m_send_ff) begin
            send_in = 1'b1;
         end else if (m_close_ff) begin
            link_in = 1'b0;
         end
      end

      if (cmd.copy) begin
         if (!sts.copy_done) begin
            pwr_en   = 1'b1;
            pwr_addr = atrsp_pkg::PL_AW'(wr_ff + atrsp_pkg::PL_CW'(cp_ff));
            pwr_data = lrd_ff;
            cp_in    = cp_ff + atrsp_pkg::LEN_W'(1);
         end else begin
            wr_in   = wr_ff + atrsp_pkg::PL_CW'(cnt_ff);
            pend_in = accf_ff - 16'(cnt_ff);
         end
      end

      // line read address runs one ahead of the registered data
      if (cmd.lend || cmd.copy) lrd_addr = colon_ff + atrsp_pkg::LEN_W'(1) + cp_in;
      else lrd_addr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (lwr_en) line_mem[len_ff[atrsp_pkg::LINE_AW-1:0]] <= item_ff.rx_byte;
      if (lrd_addr < LINE_MAX) lrd_ff <= line_mem[lrd_addr[atrsp_pkg::LINE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pwr_en) pl_mem[pwr_addr] <= pwr_data;
      pl_rd_ff <= pl_mem[rd_ff[atrsp_pkg::PL_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;  wr_ff <= '0;  rd_ff <= '0;  pend_ff <= '0;
         link_ff <= 1'b0;  conn_ff <= 1'b0;  send_ff <= 1'b0;  prompt_ff <= 1'b0;
      end else begin
         len_ff <= len_in;  wr_ff <= wr_in;  rd_ff <= rd_in;  pend_ff <= pend_in;
         link_ff <= link_in;  conn_ff <= conn_in;  send_ff <= send_in;
         prompt_ff <= prompt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;  colon_ff <= colon_in;  win_ff <= win_in;
      m_conn_ff <= m_conn_in;  m_send_ff <= m_send_in;  m_close_ff <= m_close_in;
      hdr_ff <= hdr_in;  cfound_ff <= cfound_in;  neg_ff <= neg_in;
      ph_ff <= ph_in;  acc_ff <= acc_in;
      accf_ff <= accf_in;  cnt_ff <= cnt_in;  cp_ff <= cp_in;
      rv_ff <= rv_in;  rdat_ff <= rdat_in;  rst_ff <= rst_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.link_up      <= link_ff;
         out_ff.connect_seen <= conn_ff;
         out_ff.send_seen    <= send_ff;
         out_ff.prompt_seen  <= prompt_ff;
         out_ff.data_valid   <= rv_ff;
         out_ff.data_out     <= rdat_ff;
         out_ff.read_status  <= rst_ff;
         out_ff.stored_count <= 10'(wr_ff - rd_ff);
      end
   end

   assign rsp_data = out_ff;

endmodule

// File: src/at_response_stream_parser.sv
// top level of the modem response parser
`timescale 1ns / 1ps
// Modem response parser with a payload buffer.
// req channel: one word per command (mode, rx_byte); mode 0 feeds a modem
// byte, mode 1 pops one buffered payload byte, modes 2 to 4 arm or drop flags.
// rsp channel: exactly one word per request word, in order, holding the four
// flags after the command, the popped byte with its status, and the number
// of payload bytes still buffered.
// One request is in flight at a time; req_stall stays high from accept until
// the response is loaded into the output register.
// Most words go from accept through the EXEC state to the DONE state, where
// the response is loaded, and the input reopens once that load is made. A
// line feed that closes a line adds the SCAN state, which walks the line
// buffer one byte a cycle, and the LEND state; when a +IPD header is found
// the COPY state then moves the inline payload bytes into the payload buffer.
// The single read port of the line buffer sets the pace of SCAN and COPY.
// A waiting response does not block the next request word; a stalled
// response holds its word and only the final load of the next one waits.
// Reset (synchronous, active high) clears the flags, line length, buffer
// indexes and pending count; buffer contents are not cleared and no
// clearing pass is needed.
module at_response_stream_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  atrsp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output atrsp_pkg::rsp_type rsp_data
);

   atrsp_pkg::cmd_type cmd;
   atrsp_pkg::sts_type sts;

   // sequencing
   atrsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // buffers, matcher and header parsing
   atrsp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // an accepted word closes the input until its response is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open while a word is in flight");

   // buffered count never exceeds the payload buffer
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.stored_count <= 10'(atrsp_pkg::PAYLOAD_DEPTH)))
      else $error("stored count out of range");

   // a popped byte always carries a good status
   a_pop_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.data_valid) |-> (rsp_data.read_status == atrsp_pkg::RD_OK))
      else $error("popped byte with error status");

endmodule
